>>> sv/llrq_pkg.sv
// Shared types and constants for the landmark-label reachability query block.
// No dependencies; the other files that use it refer to this package by scoped names.
package llrq_pkg;

	localparam int COMP_W  = 10;
	localparam int LABEL_W = 10;
	localparam int OP_W    = 2;

	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int MAX_LABELS_DEF   = 64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND_OUT = 2'd0,
		OP_APPEND_IN  = 2'd1,
		OP_QUERY      = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_WALK,
		ST_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic append_wr;
		logic walk_start;
		logic walk_step;
		logic res_load;
		logic res_reach;
		logic res_status;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic src_ok;
		logic dst_ok;
		logic comp_eq;
		logic comp_lt;
		logic list_full;
		logic walk_end;
		logic walk_hit;
	} dp_stat_t;

endpackage

>>> sv/llrq_req_if.sv
// Request channel: valid/ready handshake carrying one append or query item.
// Depends on llrq_pkg for field widths.
interface llrq_req_if;
	logic                            valid;
	logic                            ready;
	logic [llrq_pkg::OP_W-1:0]       opcode;
	logic [llrq_pkg::COMP_W-1:0]     source_component;
	logic [llrq_pkg::COMP_W-1:0]     target_component;
	logic [llrq_pkg::LABEL_W-1:0]    label_value;

	modport source (output valid, output opcode, output source_component,
		output target_component, output label_value, input ready);
	modport sink (input valid, input opcode, input source_component,
		input target_component, input label_value, output ready);
endinterface

>>> sv/llrq_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
// No dependencies.
interface llrq_rsp_if;
	logic valid;
	logic ready;
	logic reachable;
	logic status;

	modport source (output valid, output reachable, output status, input ready);
	modport sink (input valid, input reachable, input status, output ready);
endinterface

>>> sv/llrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llrq_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/llrq_ctrl.sv
// Controller FSM: count-clear sweep, append handling, merge-walk sequencing
// and output register valid. Depends on llrq_pkg.
module llrq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  llrq_pkg::dp_stat_t stat,
	output llrq_pkg::dp_cmd_t  cmd
);

	llrq_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic query_trivial;

	assign out_free      = !out_valid_q || rsp_ready;
	assign query_trivial = stat.comp_eq || stat.comp_lt || !stat.src_ok || !stat.dst_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= llrq_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			llrq_pkg::ST_CLEAR: begin
				if (stat.clr_last) state_d = llrq_pkg::ST_IDLE;
			end
			llrq_pkg::ST_IDLE: begin
				if (req_valid) state_d = llrq_pkg::ST_COUNT;
			end
			llrq_pkg::ST_COUNT: begin
				case (stat.op)
					llrq_pkg::OP_QUERY: begin
						state_d = query_trivial ? llrq_pkg::ST_RESULT : llrq_pkg::ST_WALK;
					end
					default: state_d = llrq_pkg::ST_RESULT;
				endcase
			end
			llrq_pkg::ST_WALK: begin
				if (stat.walk_end || stat.walk_hit) state_d = llrq_pkg::ST_RESULT;
			end
			llrq_pkg::ST_RESULT: begin
				if (out_free) state_d = llrq_pkg::ST_IDLE;
			end
			default: state_d = llrq_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			llrq_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			llrq_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			llrq_pkg::ST_COUNT: begin
				case (stat.op)
					llrq_pkg::OP_APPEND_OUT, llrq_pkg::OP_APPEND_IN: begin
						cmd.append_wr  = stat.src_ok && !stat.list_full;
						cmd.res_load   = 1'b1;
						cmd.res_status = stat.src_ok && stat.list_full;
					end
					llrq_pkg::OP_QUERY: begin
						cmd.res_load   = query_trivial;
						cmd.res_reach  = stat.comp_eq;
						cmd.walk_start = !query_trivial;
					end
					default: begin
						cmd.res_load = 1'b1;
					end
				endcase
			end
			llrq_pkg::ST_WALK: begin
				cmd.walk_step = !(stat.walk_end || stat.walk_hit);
				cmd.res_load  = stat.walk_end || stat.walk_hit;
				cmd.res_reach = stat.walk_hit;
			end
			llrq_pkg::ST_RESULT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> sv/llrq_dp.sv
// Datapath: item registers, count and label RAMs, merge-walk pointers and
// result/output registers. Depends on llrq_pkg and llrq_ram.
module llrq_dp #(
	parameter int VERTEX_COUNT = llrq_pkg::VERTEX_COUNT_DEF,
	parameter int MAX_LABELS   = llrq_pkg::MAX_LABELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [llrq_pkg::OP_W-1:0]     opcode,
	input  logic [llrq_pkg::COMP_W-1:0]   source_component,
	input  logic [llrq_pkg::COMP_W-1:0]   target_component,
	input  logic [llrq_pkg::LABEL_W-1:0]  label_value,
	input  llrq_pkg::dp_cmd_t             cmd,
	output llrq_pkg::dp_stat_t            stat,
	output logic                          reachable,
	output logic                          status
);

	localparam int VW   = $clog2(VERTEX_COUNT);
	localparam int SW   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int CW   = $clog2(MAX_LABELS + 1);
	localparam int LDEP = VERTEX_COUNT * (2 ** SW);

	logic [llrq_pkg::OP_W-1:0]    op_q;
	logic [llrq_pkg::COMP_W-1:0]  src_q, dst_q;
	logic [llrq_pkg::LABEL_W-1:0] label_q;
	logic [VW-1:0]                clr_q;
	logic [CW-1:0]                n_out_q, n_in_q;
	logic [CW-1:0]                i_q, j_q, i_d, j_d;
	logic                         res_reach_q, res_status_q;
	logic                         rsp_reach_q, rsp_status_q;

	logic [VW-1:0]                src_idx, dst_idx, req_src_idx, req_dst_idx;
	logic [CW-1:0]                out_cnt_rd, in_cnt_rd;
	logic [llrq_pkg::LABEL_W-1:0] out_lbl_rd, in_lbl_rd;
	logic                         out_cnt_we, in_cnt_we;
	logic [VW-1:0]                cnt_waddr, in_cnt_raddr;
	logic [CW-1:0]                out_cnt_wdata, in_cnt_wdata;
	logic                         out_lbl_we, in_lbl_we;
	logic                         is_out_append, is_in_append;
	logic                         exhausted;
	logic                         a_le_b;

	assign src_idx     = VW'(src_q);
	assign dst_idx     = VW'(dst_q);
	assign req_src_idx = VW'(source_component);
	assign req_dst_idx = VW'(target_component);

	assign is_out_append = (op_q == llrq_pkg::OP_APPEND_OUT);
	assign is_in_append  = (op_q == llrq_pkg::OP_APPEND_IN);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			src_q   <= source_component;
			dst_q   <= target_component;
			label_q <= label_value;
		end
	end

	// count clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + VW'(1);
		end
	end

	// count RAMs: read with the incoming item, write on clear or append
	assign cnt_waddr     = cmd.clr_step ? clr_q : src_idx;
	assign out_cnt_we    = cmd.clr_step || (cmd.append_wr && is_out_append);
	assign in_cnt_we     = cmd.clr_step || (cmd.append_wr && is_in_append);
	assign out_cnt_wdata = cmd.clr_step ? '0 : out_cnt_rd + CW'(1);
	assign in_cnt_wdata  = cmd.clr_step ? '0 : in_cnt_rd + CW'(1);
	assign in_cnt_raddr  = (opcode == llrq_pkg::OP_QUERY) ? req_dst_idx : req_src_idx;

	llrq_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_out_cnt (
		.clk   (clk),
		.we    (out_cnt_we),
		.waddr (cnt_waddr),
		.wdata (out_cnt_wdata),
		.raddr (req_src_idx),
		.rdata (out_cnt_rd)
	);

	llrq_ram #(.WIDTH(CW), .DEPTH(VERTEX_COUNT)) u_in_cnt (
		.clk   (clk),
		.we    (in_cnt_we),
		.waddr (cnt_waddr),
		.wdata (in_cnt_wdata),
		.raddr (in_cnt_raddr),
		.rdata (in_cnt_rd)
	);

	// label RAMs, addressed {vertex, slot}
	assign out_lbl_we = cmd.append_wr && is_out_append;
	assign in_lbl_we  = cmd.append_wr && is_in_append;

	llrq_ram #(.WIDTH(llrq_pkg::LABEL_W), .DEPTH(LDEP)) u_out_lbl (
		.clk   (clk),
		.we    (out_lbl_we),
		.waddr ({src_idx, out_cnt_rd[SW-1:0]}),
		.wdata (label_q),
		.raddr ({src_idx, i_d[SW-1:0]}),
		.rdata (out_lbl_rd)
	);

	llrq_ram #(.WIDTH(llrq_pkg::LABEL_W), .DEPTH(LDEP)) u_in_lbl (
		.clk   (clk),
		.we    (in_lbl_we),
		.waddr ({src_idx, in_cnt_rd[SW-1:0]}),
		.wdata (label_q),
		.raddr ({dst_idx, j_d[SW-1:0]}),
		.rdata (in_lbl_rd)
	);

	// merge walk: read data always belongs to the current i_q/j_q
	assign exhausted = (i_q >= n_out_q) || (j_q >= n_in_q);
	assign a_le_b    = (out_lbl_rd <= in_lbl_rd);

	always_comb begin
		i_d = i_q;
		j_d = j_q;
		if (cmd.walk_start) begin
			i_d = '0;
			j_d = '0;
		end else if (cmd.walk_step) begin
			if (a_le_b) begin
				i_d = i_q + CW'(1);
			end else begin
				j_d = j_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		if (cmd.walk_start) begin
			n_out_q <= out_cnt_rd;
			n_in_q  <= in_cnt_rd;
		end
		if (cmd.res_load) begin
			res_reach_q  <= cmd.res_reach;
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			rsp_reach_q  <= res_reach_q;
			rsp_status_q <= res_status_q;
		end
	end

	always_comb begin
		stat.clr_last  = (clr_q == VW'(VERTEX_COUNT - 1));
		stat.op        = llrq_pkg::op_t'(op_q);
		stat.src_ok    = (32'(src_q) < VERTEX_COUNT);
		stat.dst_ok    = (32'(dst_q) < VERTEX_COUNT);
		stat.comp_eq   = (src_q == dst_q);
		stat.comp_lt   = (src_q < dst_q);
		stat.list_full = (is_in_append ? in_cnt_rd : out_cnt_rd) >= CW'(MAX_LABELS);
		stat.walk_end  = exhausted;
		stat.walk_hit  = !exhausted && (out_lbl_rd == in_lbl_rd);
	end

	assign reachable = rsp_reach_q;
	assign status    = rsp_status_q;

endmodule

>>> sv/landmark_label_reachability_query.sv
// After reset the block sweeps the per-vertex label counts to zero, one vertex a cycle, so it
// takes no item until the sweep is done. An append goes through the transfer and count read,
// then the store write and result register load, then the output register load once that
// register is free. A query with equal components, a source below the target or an
// out-of-range component takes the same path without a store write; otherwise it merge-walks
// the out-labels of the source against the in-labels of the target, one label comparison per
// cycle out of the two label RAMs, until a list is used up or two labels match. One item is
// worked at a time; the finished result sits in an output register, so the next item is taken
// while it waits, and a second finished result holds the input off until the output register
// frees up.
// Depends on llrq_pkg, llrq_req_if, llrq_rsp_if, llrq_ctrl, llrq_dp.
module landmark_label_reachability_query #(
	parameter int VERTEX_COUNT = llrq_pkg::VERTEX_COUNT_DEF,
	parameter int MAX_LABELS   = llrq_pkg::MAX_LABELS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	llrq_req_if.sink  req,
	llrq_rsp_if.source rsp
);

	llrq_pkg::dp_cmd_t  cmd;
	llrq_pkg::dp_stat_t stat;

	llrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	llrq_dp #(
		.VERTEX_COUNT (VERTEX_COUNT),
		.MAX_LABELS   (MAX_LABELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.opcode           (req.opcode),
		.source_component (req.source_component),
		.target_component (req.target_component),
		.label_value      (req.label_value),
		.cmd              (cmd),
		.stat             (stat),
		.reachable        (rsp.reachable),
		.status           (rsp.status)
	);

endmodule

>>> sv/llrq_checker.sv
// Port-level checks for landmark_label_reachability_query, attached by bind.
// No package dependency; sees only the top-level ports.
module llrq_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_reachable,
	input logic rsp_status
);

	logic [1:0] pending_q;
	logic       req_xfer, rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// items taken whose result has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (!req_xfer && rsp_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reachable) && $stable(rsp_status))
		else $error("response changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer |-> pending_q != 2'd0)
		else $error("response with no item outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |-> pending_q < 2'd2)
		else $error("item taken with two results outstanding");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_reachable && rsp_status))
		else $error("dropped append reported as reachable");

endmodule

bind landmark_label_reachability_query llrq_checker u_llrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_reachable (rsp.reachable),
	.rsp_status    (rsp.status)
);

>>> dv/tb_top.sv
// Testbench for landmark_label_reachability_query: directed table, then random append, query and unused-opcode traffic.
// Predicts each answer from a local copy of the label lists and checks every response transfer.
// Depends on llrq_pkg, llrq_req_if, llrq_rsp_if and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VERTICES     = llrq_pkg::VERTEX_COUNT_DEF;
	localparam int LABELS       = llrq_pkg::MAX_LABELS_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOT_COUNT    = 12;

	// not a member of op_t: the block must treat it as a no-op
	localparam logic [llrq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic reach;
		logic status;
	} answer_t;

	typedef struct {
		logic [llrq_pkg::OP_W-1:0]    op;
		logic [llrq_pkg::COMP_W-1:0]  src;
		logic [llrq_pkg::COMP_W-1:0]  dst;
		logic [llrq_pkg::LABEL_W-1:0] lbl;
		int                           reps;
		int                           step;
		bit                           typed;
		answer_t                      ans;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	llrq_req_if req_ch ();
	llrq_rsp_if rsp_ch ();

	landmark_label_reachability_query #(
		.VERTEX_COUNT(VERTICES),
		.MAX_LABELS  (LABELS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the label store
	logic [llrq_pkg::LABEL_W-1:0] out_lab [VERTICES][LABELS];
	logic [llrq_pkg::LABEL_W-1:0] in_lab  [VERTICES][LABELS];
	int out_cnt [VERTICES];
	int in_cnt  [VERTICES];

	answer_t   awaited_answers [$];
	stim_row_t stim_rows [$];
	int      errors;
	int      checked;
	int      accepted;
	int      cycles;
	int      calm_items;
	bit      rx_holding;
	logic [llrq_pkg::COMP_W-1:0] hot [HOT_COUNT];

	function automatic void compute_answer(input logic [1:0] op, input logic [9:0] src,
			input logic [9:0] dst, input logic [9:0] lbl, output answer_t ans);
		int i;
		int j;
		ans = '0;
		case (op)
			llrq_pkg::OP_APPEND_OUT: begin
				if (src < VERTICES) begin
					if (out_cnt[src] >= LABELS) begin
						ans.status = 1'b1;
					end else begin
						out_lab[src][out_cnt[src]] = lbl;
						out_cnt[src]++;
					end
				end
			end
			llrq_pkg::OP_APPEND_IN: begin
				if (src < VERTICES) begin
					if (in_cnt[src] >= LABELS) begin
						ans.status = 1'b1;
					end else begin
						in_lab[src][in_cnt[src]] = lbl;
						in_cnt[src]++;
					end
				end
			end
			llrq_pkg::OP_QUERY: begin
				if (src == dst) begin
					ans.reach = 1'b1;
				end else if (src > dst && src < VERTICES && dst < VERTICES) begin
					i = 0;
					j = 0;
					// merge walk on stored order, sorted or not
					while (i < out_cnt[src] && j < in_cnt[dst] && !ans.reach) begin
						if (out_lab[src][i] == in_lab[dst][j])
							ans.reach = 1'b1;
						else if (out_lab[src][i] <= in_lab[dst][j])
							i++;
						else
							j++;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int sender_gap();
		int roll;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_items = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// next label above the tail of the list, so appends stay ascending
	function automatic logic [9:0] next_label(input logic [1:0] op, input logic [9:0] v);
		int n;
		int base;
		n = (op == llrq_pkg::OP_APPEND_OUT) ? out_cnt[v] : in_cnt[v];
		if (n == 0)
			return 10'($urandom_range(0, 15));
		base = (op == llrq_pkg::OP_APPEND_OUT) ? out_lab[v][n-1] : in_lab[v][n-1];
		base += $urandom_range(1, 12);
		return (base > 1023) ? 10'd1023 : 10'(base);
	endfunction

	function automatic logic [9:0] pick_vertex();
		if ($urandom_range(0, 3) != 0)
			return hot[$urandom_range(0, HOT_COUNT-1)];
		return 10'($urandom);
	endfunction

	function automatic stim_row_t mk_row(input logic [1:0] op, input logic [9:0] src,
			input logic [9:0] dst, input logic [9:0] lbl, input int reps, input int step,
			input bit typed, input logic reach, input logic status);
		stim_row_t r;
		r.op    = op;
		r.src   = src;
		r.dst   = dst;
		r.lbl   = lbl;
		r.reps  = reps;
		r.step  = step;
		r.typed = typed;
		r.ans   = '{reach: reach, status: status};
		return r;
	endfunction

	function automatic void add_row(input stim_row_t r);
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	task automatic offer_item(input logic [1:0] op, input logic [9:0] src, input logic [9:0] dst,
			input logic [9:0] lbl, input bit typed, input answer_t typed_ans);
		int gap;
		answer_t ans;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid            <= 1'b1;
		req_ch.opcode           <= op;
		req_ch.source_component <= src;
		req_ch.target_component <= dst;
		req_ch.label_value      <= lbl;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		compute_answer(op, src, dst, lbl, ans);
		awaited_answers.insert(awaited_answers.size(), typed ? typed_ans : ans);
		accepted++;
	endtask

	task automatic idle_req();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		idle_req();
		while (awaited_answers.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		answer_t exp_ans;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_answers.size() == 0) begin
				$display("%0t: response with none pending: reachable=%0b status=%0b",
					$time, rsp_ch.reachable, rsp_ch.status);
				errors++;
			end else begin
				exp_ans = awaited_answers.pop_front();
				if (rsp_ch.reachable !== exp_ans.reach) begin
					$display("%0t: reachable mismatch: expected %0b, got %0b",
						$time, exp_ans.reach, rsp_ch.reachable);
					errors++;
				end
				if (rsp_ch.status !== exp_ans.status) begin
					$display("%0t: status mismatch: expected %0b, got %0b",
						$time, exp_ans.status, rsp_ch.status);
					errors++;
				end
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// response pacing: short and long stalls, calm stretches, one long hold-off
	initial begin
		int stall_left;
		int calm_left;
		int hold_left;
		int roll;
		bit held_once;
		stall_left   = 0;
		calm_left    = 0;
		hold_left    = 0;
		held_once    = 1'b0;
		rx_holding   = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held_once && checked >= 250) begin
				held_once  = 1'b1;
				hold_left  = 600;
				rx_holding = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_holding = (hold_left > 0);
				rsp_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					calm_left = $urandom_range(50, 200);
					rsp_ch.ready <= 1'b1;
				end else if (roll < 70) begin
					rsp_ch.ready <= 1'b1;
				end else if (roll < 95) begin
					stall_left = $urandom_range(0, 2);
					rsp_ch.ready <= 1'b0;
				end else begin
					stall_left = $urandom_range(9, 39);
					rsp_ch.ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int roll;
		int n;
		int target_items;
		logic [1:0] op;
		logic [9:0] s;
		logic [9:0] d;
		logic [9:0] tmp;

		arst_n                  = 1'b0;
		req_ch.valid            = 1'b0;
		req_ch.opcode           = '0;
		req_ch.source_component = '0;
		req_ch.target_component = '0;
		req_ch.label_value      = '0;
		errors     = 0;
		checked    = 0;
		accepted   = 0;
		cycles     = 0;
		calm_items = 0;
		foreach (hot[k])
			hot[k] = 10'($urandom);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// equal components, source below target, empty lists, unused opcode, then short lists
		add_row(mk_row(llrq_pkg::OP_QUERY, 0, 0, 10'h3ff, 1, 0, 1, 1, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 1023, 0, 1, 0, 1, 1, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 0, 1023, 0, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 0, 10'h155, 1, 0, 1, 0, 0));
		add_row(mk_row(OP_UNUSED, 1023, 1023, 1023, 1, 0, 1, 0, 0));
		add_row(mk_row(OP_UNUSED, 0, 0, 0, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_OUT, 1023, 10'h2aa, 0, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_OUT, 1023, 0, 5, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_OUT, 1023, 1023, 1023, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 0, 0, 5, 1, 0, 1, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 0, 0, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 1, 0, 3, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 1, 0, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 1, 0, 1023, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 1, 0, 1, 0, 0, 0, 0));
		// out-of-order in-list
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 2, 0, 900, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 2, 0, 5, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 1023, 2, 0, 1, 0, 0, 0, 0));
		// two full disjoint lists: longest walk, then appends past the end
		add_row(mk_row(llrq_pkg::OP_APPEND_OUT, 10, 0, 0, LABELS, 2, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 4, 0, 1, LABELS, 2, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 10, 4, 0, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_APPEND_OUT, 10, 0, 200, 1, 0, 1, 0, 1));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 4, 1023, 1023, 1, 0, 1, 0, 1));
		add_row(mk_row(llrq_pkg::OP_APPEND_IN, 3, 0, 126, 1, 0, 0, 0, 0));
		add_row(mk_row(llrq_pkg::OP_QUERY, 10, 3, 0, 1, 0, 0, 0, 0));

		foreach (stim_rows[r])
			for (int k = 0; k < stim_rows[r].reps; k++)
				offer_item(stim_rows[r].op, stim_rows[r].src, stim_rows[r].dst,
					10'(stim_rows[r].lbl + k * stim_rows[r].step), stim_rows[r].typed,
					stim_rows[r].ans);
		drain();

		target_items = accepted + RANDOM_ITEMS;
		while (accepted < target_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				// fill one list of a hot vertex and run a few appends past full
				s  = hot[$urandom_range(0, HOT_COUNT-1)];
				op = $urandom_range(0, 1) ? llrq_pkg::OP_APPEND_IN : llrq_pkg::OP_APPEND_OUT;
				n  = LABELS - ((op == llrq_pkg::OP_APPEND_OUT) ? out_cnt[s] : in_cnt[s]);
				n += $urandom_range(1, 3);
				repeat (n)
					offer_item(op, s, 10'($urandom), next_label(op, s), 0, '0);
			end else if (roll < 64) begin
				s = pick_vertex();
				d = pick_vertex();
				if (s < d) begin
					tmp = s;
					s   = d;
					d   = tmp;
				end
				repeat ($urandom_range(0, 3))
					offer_item(llrq_pkg::OP_APPEND_OUT, s, 10'($urandom),
						next_label(llrq_pkg::OP_APPEND_OUT, s), 0, '0);
				repeat ($urandom_range(0, 3))
					offer_item(llrq_pkg::OP_APPEND_IN, d, 10'($urandom),
						next_label(llrq_pkg::OP_APPEND_IN, d), 0, '0);
				repeat ($urandom_range(1, 2))
					offer_item(llrq_pkg::OP_QUERY, s, d, 10'($urandom), 0, '0);
			end else if (roll < 84) begin
				s = pick_vertex();
				d = ($urandom_range(0, 9) == 0) ? s : pick_vertex();
				offer_item(llrq_pkg::OP_QUERY, s, d, 10'($urandom), 0, '0);
			end else begin
				offer_item(2'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 0, '0);
			end
			if ($urandom_range(0, 99) == 0 && !rx_holding)
				drain();
		end

		drain();
		repeat (2 * LABELS + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
